### rtl/core/nls_pkg.sv
// shared types and constants for the nearest light selector
package nls_pkg;
  localparam int MaxLightsDefault = 64;
  localparam int CoordW = 16;
  localparam int DistW = 34;
  localparam int AmountW = 7;
  localparam int RadiusW = 15;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NEIGHBORS = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_FULL = 2'd1,
    ST_FEW = 2'd2,
    ST_NONE = 2'd3
  } status_t;

  localparam logic CFG_MAX_AMOUNT = 1'b0;
  localparam logic CFG_RADIUS = 1'b1;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } pos_t;

  function automatic logic [DistW-1:0] dist_sq(input pos_t a, input pos_t b);
    logic signed [CoordW:0] dx;
    logic signed [CoordW:0] dy;
    logic signed [CoordW:0] dz;
    logic signed [2*CoordW+1:0] sx;
    logic signed [2*CoordW+1:0] sy;
    logic signed [2*CoordW+1:0] sz;
    dx = {a.x[CoordW-1], a.x} - {b.x[CoordW-1], b.x};
    dy = {a.y[CoordW-1], a.y} - {b.y[CoordW-1], b.y};
    dz = {a.z[CoordW-1], a.z} - {b.z[CoordW-1], b.z};
    sx = dx * dx;
    sy = dy * dy;
    sz = dz * dz;
    return $unsigned(sx + sy + sz);
  endfunction
endpackage

### rtl/core/nls_cell.sv
// one stage of the distance chain: keeps the smallest untaken distance seen
module nls_cell import nls_pkg::*; #(
  parameter int IdxW = 6
) (
  input  logic clk,
  input  logic clear,
  input  logic shift,
  input  logic in_valid,
  input  logic [DistW-1:0] in_dist,
  input  logic [IdxW-1:0] in_idx,
  input  logic nb_held,
  input  logic [DistW-1:0] nb_dist,
  input  logic [IdxW-1:0] nb_idx,
  output logic out_valid,
  output logic [DistW-1:0] out_dist,
  output logic [IdxW-1:0] out_idx,
  output logic held,
  output logic [DistW-1:0] held_dist,
  output logic [IdxW-1:0] held_idx
);
  logic keep;

  // displaced entries can trail higher indices: equal distance goes to the lower index
  assign keep = held && !(in_valid && (in_dist < held_dist ||
                (in_dist == held_dist && in_idx < held_idx)));

  always_ff @(posedge clk) begin
    if (clear) begin
      held <= 1'b0;
      out_valid <= 1'b0;
    end else if (shift) begin
      // sorted readout: move toward the head
      held <= nb_held;
      held_dist <= nb_dist;
      held_idx <= nb_idx;
      out_valid <= 1'b0;
    end else begin
      if (in_valid && !keep) begin
        held <= 1'b1;
        held_dist <= in_dist;
        held_idx <= in_idx;
        out_valid <= held;
        out_dist <= held_dist;
        out_idx <= held_idx;
      end else begin
        out_valid <= in_valid;
        out_dist <= in_dist;
        out_idx <= in_idx;
      end
    end
  end
endmodule

### rtl/core/nearest_light_selector.sv
// top level: light table, cell chain for sorted query, pairwise neighbor counter
// add, remove and empty cases: word in the cycle after start, then S_DONE before idle
// nearest query (n lights, k words): S_FEED feeds the n lights, S_DRAIN lets the chain settle,
//   then S_EMIT sends the k words back to back, nearest first
// max neighbors: S_PAIR walks all n*n pairs, S_PAIRW drains the pipeline, word on return to idle
// words cannot be held off; synchronous reset clears count and control, restores config defaults
module nearest_light_selector import nls_pkg::*; #(
  parameter int MAX_LIGHTS = MaxLightsDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [1:0] command,
  input  logic signed [CoordW-1:0] pos_x,
  input  logic signed [CoordW-1:0] pos_y,
  input  logic signed [CoordW-1:0] pos_z,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [RadiusW-1:0] cfg_data,
  output logic strobe,
  output logic [1:0] status,
  output logic [5:0] light_index,
  output logic [DistW-1:0] distance_sq,
  output logic [6:0] neighbor_count,
  output logic last
);
  localparam int IdxW = $clog2(MAX_LIGHTS);
  localparam int CntW = $clog2(MAX_LIGHTS + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_FEED = 7'b0000010, S_DRAIN = 7'b0000100,
    S_EMIT = 7'b0001000, S_PAIR = 7'b0010000, S_PAIRW = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state;
  logic [AmountW-1:0] max_amount;
  logic [RadiusW-1:0] neighbor_radius;
  logic [CntW-1:0] light_count;
  pos_t mem [MAX_LIGHTS];
  pos_t center, rd_a, rd_b;
  logic [IdxW-1:0] addr_a, addr_b;
  logic [CntW-1:0] ci, cj, want, emitted, cnt, best;
  logic [CntW-1:0] tick;
  logic feed_v, pair_end;

  logic [MAX_LIGHTS:0] cv;
  logic [DistW-1:0] cd [MAX_LIGHTS+1];
  logic [IdxW-1:0] cx [MAX_LIGHTS+1];
  logic [MAX_LIGHTS:0] hv;
  logic [DistW-1:0] hd [MAX_LIGHTS+1];
  logic [IdxW-1:0] hx [MAX_LIGHTS+1];
  logic clr, shift;
  logic [IdxW-1:0] feed_idx;
  logic [2*RadiusW-1:0] r2;
  logic [DistW-1:0] pd;

  logic pv1, pv2, pend1, pend2;
  logic [CntW-1:0] pj1, pj2;

  assign busy = (state != S_IDLE);
  assign r2 = neighbor_radius * neighbor_radius;

  always_ff @(posedge clk) begin
    if (start && !busy && command == CMD_ADD && light_count < CntW'(MAX_LIGHTS))
      mem[light_count[IdxW-1:0]] <= '{x: pos_x, y: pos_y, z: pos_z};
    rd_a <= mem[addr_a];
    rd_b <= mem[addr_b];
  end

  assign addr_a = ci[IdxW-1:0];
  assign addr_b = cj[IdxW-1:0];

  // chain of cells, each holding one sorted candidate
  assign cv[0] = feed_v;
  assign cd[0] = dist_sq(center, rd_a);
  assign cx[0] = feed_idx;
  assign hv[MAX_LIGHTS] = 1'b0;
  assign hd[MAX_LIGHTS] = '0;
  assign hx[MAX_LIGHTS] = '0;
  genvar g;
  generate
    for (g = 0; g < MAX_LIGHTS; g++) begin : g_cell
      nls_cell #(.IdxW(IdxW)) u_cell (
        .clk(clk), .clear(clr), .shift(shift), .in_valid(cv[g]), .in_dist(cd[g]),
        .in_idx(cx[g]), .nb_held(hv[g+1]), .nb_dist(hd[g+1]), .nb_idx(hx[g+1]),
        .out_valid(cv[g+1]), .out_dist(cd[g+1]), .out_idx(cx[g+1]),
        .held(hv[g]), .held_dist(hd[g]), .held_idx(hx[g])
      );
    end
  endgenerate
  assign clr = rst || (start && !busy);
  assign shift = (state == S_EMIT);

  always_ff @(posedge clk) begin
    pd <= dist_sq(rd_a, rd_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      max_amount <= AmountW'(8);
      neighbor_radius <= RadiusW'(800);
      light_count <= '0;
      strobe <= 1'b0;
      feed_v <= 1'b0;
    end else begin
      strobe <= 1'b0;
      status <= ST_OK;
      light_index <= '0;
      distance_sq <= '0;
      neighbor_count <= '0;
      last <= 1'b1;
      feed_v <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == CFG_MAX_AMOUNT) max_amount <= cfg_data[AmountW-1:0];
        else neighbor_radius <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            center <= '{x: pos_x, y: pos_y, z: pos_z};
            ci <= '0;
            cj <= '0;
            cnt <= '0;
            best <= '0;
            tick <= '0;
            emitted <= '0;
            want <= (max_amount < AmountW'(light_count)) ? CntW'(max_amount) : light_count;
            unique case (cmd_t'(command))
              CMD_ADD: begin
                strobe <= 1'b1;
                if (light_count >= CntW'(MAX_LIGHTS)) status <= ST_FULL;
                else light_count <= light_count + CntW'(1);
                state <= S_DONE;
              end
              CMD_REMOVE: begin
                strobe <= 1'b1;
                if (light_count < CntW'(4)) status <= ST_FEW;
                else light_count <= light_count - CntW'(4);
                state <= S_DONE;
              end
              CMD_QUERY: begin
                if (light_count == '0 || max_amount == '0) begin
                  strobe <= 1'b1;
                  status <= ST_NONE;
                  state <= S_DONE;
                end else state <= S_FEED;
              end
              CMD_NEIGHBORS: begin
                if (light_count == '0) begin
                  strobe <= 1'b1;
                  state <= S_DONE;
                end else state <= S_PAIR;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_FEED: begin
          // read issued this cycle, fed next cycle
          feed_v <= 1'b1;
          feed_idx <= ci[IdxW-1:0];
          if (ci == light_count - CntW'(1)) state <= S_DRAIN;
          else ci <= ci + CntW'(1);
        end
        S_DRAIN: begin
          tick <= tick + CntW'(1);
          if (tick == light_count) state <= S_EMIT;
        end
        S_EMIT: begin
          // head cell holds the smallest remaining entry
          strobe <= 1'b1;
          light_index <= 6'(hx[0]);
          distance_sq <= hd[0];
          last <= (emitted == want - CntW'(1));
          emitted <= emitted + CntW'(1);
          if (emitted == want - CntW'(1)) state <= S_IDLE;
        end
        S_PAIR: begin
          if (cj == light_count - CntW'(1)) begin
            cj <= '0;
            ci <= ci + CntW'(1);
          end else cj <= cj + CntW'(1);
          if (cj == light_count - CntW'(1) && ci == light_count - CntW'(1))
            state <= S_PAIRW;
        end
        S_PAIRW: begin
          if (pend2) state <= S_IDLE;
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase

      // pair pipeline: address -> read -> distance, with pv1 and pv2 tracking the registered stages
      if (pv2) begin
        if (pd < DistW'(r2)) begin
          if (pj2 == light_count - CntW'(1)) begin
            if (cnt + CntW'(1) > best) best <= cnt + CntW'(1);
            cnt <= '0;
          end else cnt <= cnt + CntW'(1);
        end else if (pj2 == light_count - CntW'(1)) begin
          if (cnt > best) best <= cnt;
          cnt <= '0;
        end
        if (pend2) begin
          strobe <= 1'b1;
          neighbor_count <= 7'((pd < DistW'(r2) && cnt + CntW'(1) > best) ?
                               cnt + CntW'(1) : (cnt > best ? cnt : best));
        end
      end
    end
  end

  // pair pipeline bookkeeping
  assign pair_end = (state == S_PAIR) && cj == light_count - CntW'(1) &&
                    ci == light_count - CntW'(1);
  always_ff @(posedge clk) begin
    if (rst) begin
      pv1 <= 1'b0;
      pv2 <= 1'b0;
    end else begin
      pv1 <= (state == S_PAIR);
      pv2 <= pv1;
    end
    pend1 <= pair_end;
    pend2 <= pend1;
    pj1 <= cj;
    pj2 <= pj1;
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state));
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    light_count <= CntW'(MAX_LIGHTS));
  a_chain_no_overflow: assert property (@(posedge clk) disable iff (rst) !cv[MAX_LIGHTS]);
  a_head_held: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> hv[0]);
endmodule
